[rtl/gwt_pkg.sv]
`default_nettype none
package gwt_pkg;

    localparam int NODES_DEF    = 4096;
    localparam int MAX_WORD_DEF = 16;
    localparam int ALPHABET     = 32;
    localparam int LETTER_W     = 5;
    localparam int CHAR_W       = 8;
    localparam int NODE_W       = 12;
    localparam int COUNT_W      = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_FOLLOW = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FAIL    = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_QUERY = 8'd63;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_SHIFT = 8'd32;
    localparam logic [7:0] LETTER_BASE = 8'd96;
    localparam logic [4:0] IDX_SEP   = 5'd0;
    localparam logic [4:0] IDX_QUERY = 5'd31;

    typedef struct packed {
        logic [1:0]          operation;
        logic [CHAR_W-1:0]   character;
        logic                last;
        logic [NODE_W-1:0]   node;
    } item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                found;
        logic [NODE_W-1:0]   edge_dest;
        logic                in_letter_set;
        logic [COUNT_W-1:0]  word_count;
    } result_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [LETTER_W-1:0] letter;
        logic                bad;
        logic                last;
        logic [NODE_W-1:0]   node;
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FOLLOW,
        S_WALK,
        S_WALK_CHK,
        S_LS_RD,
        S_LS_WR,
        S_FORCE_RD,
        S_FORCE_CHK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_SEP,
        PH_FORCED,
        PH_TEST
    } phase_t;

    function automatic logic [LETTER_W:0] letter_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        logic [LETTER_W:0] r;
        lc = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            lc = c + CASE_SHIFT;
        end
        priority if (lc == CH_PLUS)
        begin
            r = {1'b1, IDX_SEP};
        end
        else if (lc == CH_QUERY)
        begin
            r = {1'b1, IDX_QUERY};
        end
        else if (lc >= CH_LOWER_A && lc <= CH_LOWER_Z)
        begin
            r = {1'b1, LETTER_W'(lc - LETTER_BASE)};
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/gwt_ram.sv]
`default_nettype none
module gwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/gwt_front.sv]
`default_nettype none
module gwt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire gwt_pkg::item_t item,
    input  wire logic          hold,
    output logic               cmd_valid,
    input  wire logic          cmd_take,
    output gwt_pkg::cmd_t      cmd
);

    gwt_pkg::cmd_t q_reg [2];
    gwt_pkg::cmd_t enq_cmd;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic [gwt_pkg::LETTER_W:0] mapped;
    logic          enq;
    logic          deq;

    assign full      = (count_reg == 2'd2) || hold;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        mapped            = gwt_pkg::letter_map(item.character);
        enq_cmd.operation = item.operation;
        enq_cmd.letter    = mapped[gwt_pkg::LETTER_W-1:0];
        enq_cmd.bad       = !mapped[gwt_pkg::LETTER_W];
        enq_cmd.last      = item.last;
        enq_cmd.node      = item.node;
        enq         = push && !full && (item.operation != gwt_pkg::OP_NONE);
        deq         = cmd_take && cmd_valid;
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/gwt_back.sv]
`default_nettype none
module gwt_back #(
    parameter int NODES    = gwt_pkg::NODES_DEF,
    parameter int MAX_WORD = gwt_pkg::MAX_WORD_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_take,
    input  wire gwt_pkg::cmd_t            cmd,
    output logic                          empty,
    input  wire logic                     pop,
    output gwt_pkg::result_t              result,
    output logic                          clearing,
    output logic [$clog2(NODES):0]        node_count
);

    localparam int NW = $clog2(NODES);
    localparam int BW = $clog2(MAX_WORD);
    localparam int LW = BW + 1;
    localparam int LTW = gwt_pkg::LETTER_W;
    localparam int EA = NW + LTW;

    gwt_pkg::state_t  state_reg, state_next;
    gwt_pkg::phase_t  phase_reg, phase_next;
    logic [EA-1:0]    clr_reg, clr_next;
    logic [NW:0]      count_reg, count_next;
    logic [gwt_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [LW-1:0]    wlen_reg, wlen_next;
    logic             bad_reg, bad_next;
    logic             out_valid_reg, out_valid_next;

    logic [NW-1:0]    nd_reg, nd_next;
    logic [NW-1:0]    target_reg, target_next;
    logic [BW-1:0]    pos_reg, pos_next;
    logic [BW-1:0]    m_reg, m_next;
    logic             at_sep_reg, at_sep_next;
    logic [LW-1:0]    seq_len_reg, seq_len_next;
    logic [EA-1:0]    eaddr_reg, eaddr_next;
    logic [LTW-1:0]   buf_reg [MAX_WORD];
    logic [LTW-1:0]   buf_next [MAX_WORD];
    gwt_pkg::result_t res_reg, res_next;
    gwt_pkg::result_t out_reg, out_next;

    logic             e_we;
    logic [EA-1:0]    e_waddr;
    logic [NW-1:0]    e_wdata;
    logic [EA-1:0]    e_raddr;
    logic [NW-1:0]    e_rdata;
    logic             l_we;
    logic [NW-1:0]    l_waddr;
    logic [gwt_pkg::ALPHABET-1:0] l_wdata;
    logic [NW-1:0]    l_raddr;
    logic [gwt_pkg::ALPHABET-1:0] l_rdata;

    logic [BW-1:0]    buf_idx;
    logic [LTW-1:0]   buf_char;
    logic [LTW-1:0]   walk_char;
    logic [31:0]      node32;
    logic [31:0]      edata32;
    logic             char_bad;
    logic             bad_now;
    logic [LW-1:0]    len_now;
    logic [LW-1:0]    len_now_m1;
    logic [LW-1:0]    len_m1;
    logic [LW-1:0]    len_m2;
    logic [LW-1:0]    len_m3;
    logic [BW-1:0]    pos_stop;
    logic             sep_phase;
    logic             table_full;

    gwt_ram #(.WIDTH(NW), .DEPTH(NODES * gwt_pkg::ALPHABET)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    gwt_ram #(.WIDTH(gwt_pkg::ALPHABET), .DEPTH(NODES)) u_set_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign empty      = !out_valid_reg;
    assign result     = out_reg;
    assign clearing   = (state_reg == gwt_pkg::S_CLEAR);
    assign node_count = count_reg;

    assign buf_char   = buf_reg[buf_idx];
    assign walk_char  = at_sep_reg ? gwt_pkg::IDX_SEP : buf_char;
    assign node32     = 32'(cmd.node);
    assign edata32    = 32'(e_rdata);
    assign len_m1     = seq_len_reg - LW'(1);
    assign len_m2     = seq_len_reg - LW'(2);
    assign len_m3     = seq_len_reg - LW'(3);
    assign sep_phase  = (phase_reg == gwt_pkg::PH_SEP) || (phase_reg == gwt_pkg::PH_FORCED);
    assign pos_stop   = sep_phase ? BW'(0) : BW'(1);
    assign table_full = (count_reg >= (NW+1)'(NODES));

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        wlen_next      = wlen_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !pop;
        nd_next        = nd_reg;
        target_next    = target_reg;
        pos_next       = pos_reg;
        m_next         = m_reg;
        at_sep_next    = at_sep_reg;
        seq_len_next   = seq_len_reg;
        eaddr_next     = eaddr_reg;
        buf_next       = buf_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        e_we           = 1'b0;
        e_waddr        = eaddr_reg;
        e_wdata        = '0;
        e_raddr        = eaddr_reg;
        l_we           = 1'b0;
        l_waddr        = nd_reg;
        l_wdata        = l_rdata;
        l_raddr        = nd_reg;
        buf_idx        = pos_reg;
        char_bad       = cmd.bad || (wlen_reg >= LW'(MAX_WORD));
        len_now        = char_bad ? wlen_reg : wlen_reg + LW'(1);
        len_now_m1     = len_now - LW'(1);
        bad_now        = bad_reg || char_bad;

        unique case (state_reg)
            gwt_pkg::S_CLEAR:
            begin
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                e_wdata  = '0;
                l_we     = 1'b1;
                l_waddr  = clr_reg[EA-1:LTW];
                l_wdata  = '0;
                clr_next = clr_reg + EA'(1);
                if (clr_reg == {EA{1'b1}})
                begin
                    state_next = gwt_pkg::S_IDLE;
                end
            end
            gwt_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    res_next = '0;
                    if (cmd.operation == gwt_pkg::OP_FOLLOW)
                    begin
                        if (cmd.bad)
                        begin
                            res_next.status = gwt_pkg::STAT_INVALID;
                            state_next      = gwt_pkg::S_DONE;
                        end
                        else if (node32 >= NODES)
                        begin
                            state_next = gwt_pkg::S_DONE;
                        end
                        else
                        begin
                            e_raddr    = {node32[NW-1:0], cmd.letter};
                            eaddr_next = {node32[NW-1:0], cmd.letter};
                            l_raddr    = node32[NW-1:0];
                            state_next = gwt_pkg::S_FOLLOW;
                        end
                    end
                    else
                    begin
                        if (char_bad)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            buf_next[wlen_reg[BW-1:0]] = cmd.letter;
                            wlen_next = wlen_reg + LW'(1);
                        end
                        if (cmd.last)
                        begin
                            wlen_next    = '0;
                            bad_next     = 1'b0;
                            seq_len_next = len_now;
                            nd_next      = '0;
                            at_sep_next  = 1'b0;
                            pos_next     = len_now_m1[BW-1:0];
                            if (bad_now || len_now == '0)
                            begin
                                res_next.status = gwt_pkg::STAT_INVALID;
                                state_next      = gwt_pkg::S_DONE;
                            end
                            else
                            begin
                                if (cmd.operation == gwt_pkg::OP_INSERT)
                                begin
                                    phase_next = gwt_pkg::PH_LEFT;
                                    if (total_reg != {gwt_pkg::COUNT_W{1'b1}})
                                    begin
                                        total_next = total_reg + gwt_pkg::COUNT_W'(1);
                                    end
                                end
                                else
                                begin
                                    phase_next = gwt_pkg::PH_TEST;
                                end
                                state_next = (len_now == LW'(1)) ? gwt_pkg::S_LS_RD
                                                                 : gwt_pkg::S_WALK;
                            end
                        end
                    end
                end
            end
            gwt_pkg::S_FOLLOW:
            begin
                res_next.status        = gwt_pkg::STAT_OK;
                res_next.edge_dest     = edata32[gwt_pkg::NODE_W-1:0];
                res_next.in_letter_set = l_rdata[eaddr_reg[LTW-1:0]];
                state_next             = gwt_pkg::S_DONE;
            end
            gwt_pkg::S_WALK:
            begin
                e_raddr    = {nd_reg, walk_char};
                eaddr_next = {nd_reg, walk_char};
                state_next = gwt_pkg::S_WALK_CHK;
            end
            gwt_pkg::S_WALK_CHK:
            begin
                state_next = gwt_pkg::S_WALK;
                if (e_rdata != '0)
                begin
                    nd_next = e_rdata;
                end
                else if (phase_reg == gwt_pkg::PH_TEST)
                begin
                    res_next.found = 1'b0;
                    state_next     = gwt_pkg::S_DONE;
                end
                else if (table_full)
                begin
                    res_next.status = gwt_pkg::STAT_FAIL;
                    state_next      = gwt_pkg::S_DONE;
                end
                else
                begin
                    e_we       = 1'b1;
                    e_wdata    = count_reg[NW-1:0];
                    nd_next    = count_reg[NW-1:0];
                    count_next = count_reg + (NW+1)'(1);
                end
                if (state_next == gwt_pkg::S_WALK)
                begin
                    if (at_sep_reg || (pos_reg == pos_stop && !sep_phase))
                    begin
                        state_next = (phase_reg == gwt_pkg::PH_FORCED) ? gwt_pkg::S_FORCE_RD
                                                                       : gwt_pkg::S_LS_RD;
                    end
                    else if (pos_reg == pos_stop)
                    begin
                        at_sep_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg - BW'(1);
                    end
                end
            end
            gwt_pkg::S_LS_RD:
            begin
                buf_idx    = (phase_reg == gwt_pkg::PH_SEP) ? len_m1[BW-1:0] : BW'(0);
                state_next = gwt_pkg::S_LS_WR;
            end
            gwt_pkg::S_LS_WR:
            begin
                buf_idx = (phase_reg == gwt_pkg::PH_SEP) ? len_m1[BW-1:0] : BW'(0);
                if (phase_reg == gwt_pkg::PH_TEST)
                begin
                    res_next.found = l_rdata[buf_char];
                    state_next     = gwt_pkg::S_DONE;
                end
                else
                begin
                    l_we        = 1'b1;
                    l_wdata     = l_rdata | (gwt_pkg::ALPHABET'(1) << buf_char);
                    nd_next     = '0;
                    at_sep_next = 1'b0;
                    if (phase_reg == gwt_pkg::PH_LEFT && seq_len_reg != LW'(1))
                    begin
                        phase_next = gwt_pkg::PH_SEP;
                        pos_next   = len_m2[BW-1:0];
                        state_next = gwt_pkg::S_WALK;
                    end
                    else if (phase_reg == gwt_pkg::PH_SEP && seq_len_reg >= LW'(3))
                    begin
                        target_next = nd_reg;
                        phase_next  = gwt_pkg::PH_FORCED;
                        m_next      = len_m3[BW-1:0];
                        pos_next    = len_m3[BW-1:0];
                        state_next  = gwt_pkg::S_WALK;
                    end
                    else
                    begin
                        res_next.status = gwt_pkg::STAT_OK;
                        state_next      = gwt_pkg::S_DONE;
                    end
                end
            end
            gwt_pkg::S_FORCE_RD:
            begin
                buf_idx    = m_reg + BW'(1);
                e_raddr    = {nd_reg, buf_char};
                eaddr_next = {nd_reg, buf_char};
                state_next = gwt_pkg::S_FORCE_CHK;
            end
            gwt_pkg::S_FORCE_CHK:
            begin
                if (e_rdata != target_reg && e_rdata != '0)
                begin
                    res_next.status = gwt_pkg::STAT_FAIL;
                    state_next      = gwt_pkg::S_DONE;
                end
                else
                begin
                    if (e_rdata != target_reg)
                    begin
                        e_we    = 1'b1;
                        e_wdata = target_reg;
                    end
                    target_next = nd_reg;
                    if (m_reg == '0)
                    begin
                        res_next.status = gwt_pkg::STAT_OK;
                        state_next      = gwt_pkg::S_DONE;
                    end
                    else
                    begin
                        m_next      = m_reg - BW'(1);
                        pos_next    = m_reg - BW'(1);
                        nd_next     = '0;
                        at_sep_next = 1'b0;
                        state_next  = gwt_pkg::S_WALK;
                    end
                end
            end
            gwt_pkg::S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next            = res_reg;
                    out_next.word_count = total_reg;
                    out_valid_next      = 1'b1;
                    state_next          = gwt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gwt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwt_pkg::S_CLEAR;
            phase_reg     <= gwt_pkg::PH_LEFT;
            clr_reg       <= '0;
            count_reg     <= (NW+1)'(1);
            total_reg     <= '0;
            wlen_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            wlen_reg      <= wlen_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nd_reg      <= nd_next;
        target_reg  <= target_next;
        pos_reg     <= pos_next;
        m_reg       <= m_next;
        at_sep_reg  <= at_sep_next;
        seq_len_reg <= seq_len_next;
        eaddr_reg   <= eaddr_next;
        buf_reg     <= buf_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule
`default_nettype wire

[rtl/gaddag_word_table_engine.sv]
`default_nettype none
// Channel   Handshake     Payload    Moves
// input     push / full   item       one character or follow request per item
// result    pop / empty   result     one answer per last character or follow
//
// A character that is not the last of its word is buffered and gives no result.
// A follow reads the edge table and the node's letter set. A membership test
// walks the edges of the word from its end, then looks up its first letter in
// the letter set reached. Inserts walk too; each edge is read, then checked.
// After reset the edge table is cleared while full stays high.
// Two items can wait ahead of the engine and one result behind it.
module gaddag_word_table_engine #(
    parameter int NODES    = gwt_pkg::NODES_DEF,
    parameter int MAX_WORD = gwt_pkg::MAX_WORD_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire gwt_pkg::item_t   item,
    output logic                  empty,
    input  wire logic             pop,
    output gwt_pkg::result_t      result
);

    localparam int NW = $clog2(NODES);

    logic          cmd_valid;
    logic          cmd_take;
    gwt_pkg::cmd_t cmd;
    logic          clearing;
    logic [NW:0]   node_count;

    gwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .hold      (clearing),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    gwt_back #(.NODES(NODES), .MAX_WORD(MAX_WORD)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd        (cmd),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .clearing   (clearing),
        .node_count (node_count)
    );

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("item accepted during table clear");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> empty)
        else $error("result offered during table clear");

    a_node_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (node_count <= (NW+1)'(NODES)) && (node_count != '0))
        else $error("node count outside its range");

endmodule
`default_nettype wire
